>>> sv/hsvapa_pkg.sv
package hsvapa_pkg;

  // Frame layout
  localparam int FRAME_BYTES = 10;
  localparam int BYTE_CNT_W  = 4;
  localparam logic [BYTE_CNT_W-1:0] BYTE_GLOBAL = BYTE_CNT_W'(5);
  localparam logic [BYTE_CNT_W-1:0] BYTE_BLUE   = BYTE_CNT_W'(6);
  localparam logic [BYTE_CNT_W-1:0] BYTE_GREEN  = BYTE_CNT_W'(7);
  localparam logic [BYTE_CNT_W-1:0] BYTE_RED    = BYTE_CNT_W'(8);
  localparam logic [BYTE_CNT_W-1:0] BYTE_END    = BYTE_CNT_W'(FRAME_BYTES - 1);

  localparam logic [7:0] START_MARK  = 8'h00;
  localparam logic [7:0] GLOBAL_MARK = 8'hE0;
  localparam logic [7:0] END_MARK    = 8'hFF;
  localparam logic [7:0] CHAN_MAX    = 8'hFF;

  // Command codes
  localparam logic CMD_RGB = 1'b0;
  localparam logic CMD_HSV = 1'b1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_RED_GAIN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_GAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE_GAIN  = 2'd2;

  localparam logic [8:0] RED_GAIN_RST   = 9'd85;
  localparam logic [8:0] GREEN_GAIN_RST = 9'd64;
  localparam logic [8:0] BLUE_GAIN_RST  = 9'd256;

  // Hue arithmetic: floor(2^24/360) and ceil(2^16/60) reciprocals.
  localparam logic [31:0] HUE_RECIP     = 32'd46603;
  localparam logic [16:0] HUE_WRAP      = 17'd360;
  localparam logic [19:0] SECTOR_RECIP  = 20'd1093;
  localparam logic [8:0]  SECTOR_SPAN   = 9'd60;
  localparam logic [8:0]  UNIT          = 9'd256;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  red_in;
    logic [7:0]  green_in;
    logic [7:0]  blue_in;
    logic [15:0] hue;
    logic [7:0]  saturation;
    logic [7:0]  brightness;
  } in_item_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
    logic       regulator_on;
  } out_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] brightness;
  } color_t;

  typedef struct packed {
    logic [8:0] red_gain;
    logic [8:0] green_gain;
    logic [8:0] blue_gain;
  } gains_t;

  function automatic logic [7:0] clamp_chan(input logic [8:0] v);
    return v[8] ? CHAN_MAX : v[7:0];
  endfunction

  function automatic logic [7:0] scale_chan(input logic [7:0] chan, input logic [8:0] gain);
    logic [16:0] prod;
    prod = 17'(chan) * 17'(gain);
    return clamp_chan(prod[16:8]);
  endfunction

endpackage

>>> sv/hsv_to_apa102_frame.sv
// An accepted command passes the front pipeline, the queue, the back byte
// counter and the output register; its frame bytes then follow back to back.
// Commands are taken while busy is low, and frames leave the byte emitter back to back; up to four
// commands can be queued, and busy rises when the queue credit is used up.
// Reset (rst_n low, synchronous) empties the pipeline and queue and loads
// the gain registers with 85, 64 and 256. The receiver cannot stall.
module hsv_to_apa102_frame (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  hsvapa_pkg::in_item_t                 in_data,
  output logic                                 out_valid,
  output hsvapa_pkg::out_item_t                out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [hsvapa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [8:0]                           cfg_data
);

  hsvapa_pkg::gains_t                 gains_r;
  logic [hsvapa_pkg::QCNT_W-1:0]      inflight_r;
  logic                               accept;
  logic                               q_push, q_pop, q_empty;
  hsvapa_pkg::color_t                 q_push_data, q_head;
  logic [hsvapa_pkg::QCNT_W-1:0]      q_count;

  assign cfg_ready = 1'b1;
  // Credit covers both the front pipeline and the queue.
  assign busy   = (inflight_r == hsvapa_pkg::QCNT_W'(hsvapa_pkg::QUEUE_DEPTH));
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else if (accept && !q_pop) begin
      inflight_r <= inflight_r + 1'b1;
    end else if (q_pop && !accept) begin
      inflight_r <= inflight_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gains_r.red_gain   <= hsvapa_pkg::RED_GAIN_RST;
      gains_r.green_gain <= hsvapa_pkg::GREEN_GAIN_RST;
      gains_r.blue_gain  <= hsvapa_pkg::BLUE_GAIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        hsvapa_pkg::REG_RED_GAIN:   gains_r.red_gain   <= cfg_data;
        hsvapa_pkg::REG_GREEN_GAIN: gains_r.green_gain <= cfg_data;
        hsvapa_pkg::REG_BLUE_GAIN:  gains_r.blue_gain  <= cfg_data;
        default: ;
      endcase
    end
  end

  hsvapa_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_data   (in_data),
    .push      (q_push),
    .push_data (q_push_data)
  );

  hsvapa_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .count     (q_count)
  );

  hsvapa_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .gains     (gains_r),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef NO_ASSERTIONS
  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r <= hsvapa_pkg::QCNT_W'(hsvapa_pkg::QUEUE_DEPTH))
    else $error("in-flight count exceeds queue depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push && !q_pop |-> q_count < hsvapa_pkg::QCNT_W'(hsvapa_pkg::QUEUE_DEPTH))
    else $error("push into a full queue");

  a_queue_in_credit: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= inflight_r)
    else $error("queue holds more than the issued credit");

  a_end_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last_byte |-> out_data.frame_byte == hsvapa_pkg::END_MARK)
    else $error("last beat is not the end byte");
`endif

endmodule

>>> sv/hsvapa_front.sv
module hsvapa_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  hsvapa_pkg::in_item_t in_data,
  output logic                 push,
  output hsvapa_pkg::color_t   push_data
);

  logic                 s1_valid_r, s2_valid_r, s3_valid_r;
  hsvapa_pkg::in_item_t s1_item_r, s2_item_r, s3_item_r;
  logic [7:0]           s1_quo_r;
  logic [8:0]           s2_hue_r;
  logic [2:0]           s3_sector_r;
  logic [7:0]           s3_frac_r;

  logic [31:0] hue_prod;
  logic [7:0]  quo_nxt;
  logic [16:0] wrap_diff;
  logic [8:0]  hue_nxt;
  logic [19:0] sector_prod;
  logic [2:0]  sector_nxt;
  logic [8:0]  frac_rem;
  logic [7:0]  frac_nxt;
  logic [15:0] sf_prod;
  logic [8:0]  sf, p_val, q_val, t_val;
  logic [8:0]  r_hsv, g_hsv, b_hsv;

  // Stage 1: estimated quotient of hue by 360 (may be one low).
  always_comb begin
    hue_prod = 32'(in_data.hue) * hsvapa_pkg::HUE_RECIP;
    quo_nxt  = hue_prod[31:24];
  end

  // Stage 2: remainder with a single correction step.
  always_comb begin
    wrap_diff = 17'(s1_item_r.hue) - 17'(s1_quo_r) * hsvapa_pkg::HUE_WRAP;
    if (wrap_diff >= hsvapa_pkg::HUE_WRAP) begin
      wrap_diff = wrap_diff - hsvapa_pkg::HUE_WRAP;
    end
    hue_nxt = wrap_diff[8:0];
  end

  // Stage 3: sector and fraction scaled to the 256 unit.
  always_comb begin
    sector_prod = 20'(s2_hue_r) * hsvapa_pkg::SECTOR_RECIP;
    sector_nxt  = sector_prod[18:16];
    frac_rem    = s2_hue_r - 9'(sector_nxt) * hsvapa_pkg::SECTOR_SPAN;
    frac_nxt    = {frac_rem[5:0], 2'b00};
  end

  // Stage 4: six-sector mix, then into the queue.
  always_comb begin
    sf_prod = 16'(s3_item_r.saturation) * 16'(s3_frac_r);
    sf      = 9'(sf_prod[15:8]);
    p_val   = hsvapa_pkg::UNIT - 9'(s3_item_r.saturation);
    q_val   = hsvapa_pkg::UNIT - sf;
    t_val   = p_val + sf;
    case (s3_sector_r)
      3'd0: begin
        r_hsv = 9'(hsvapa_pkg::CHAN_MAX); g_hsv = t_val; b_hsv = p_val;
      end
      3'd1: begin
        r_hsv = q_val; g_hsv = 9'(hsvapa_pkg::CHAN_MAX); b_hsv = p_val;
      end
      3'd2: begin
        r_hsv = p_val; g_hsv = 9'(hsvapa_pkg::CHAN_MAX); b_hsv = t_val;
      end
      3'd3: begin
        r_hsv = p_val; g_hsv = q_val; b_hsv = 9'(hsvapa_pkg::CHAN_MAX);
      end
      3'd4: begin
        r_hsv = t_val; g_hsv = p_val; b_hsv = 9'(hsvapa_pkg::CHAN_MAX);
      end
      default: begin
        r_hsv = 9'(hsvapa_pkg::CHAN_MAX); g_hsv = p_val; b_hsv = q_val;
      end
    endcase
    push                 = s3_valid_r;
    push_data.brightness = s3_item_r.brightness;
    if (s3_item_r.cmd == hsvapa_pkg::CMD_HSV) begin
      push_data.red   = hsvapa_pkg::clamp_chan(r_hsv);
      push_data.green = hsvapa_pkg::clamp_chan(g_hsv);
      push_data.blue  = hsvapa_pkg::clamp_chan(b_hsv);
    end else begin
      push_data.red   = s3_item_r.red_in;
      push_data.green = s3_item_r.green_in;
      push_data.blue  = s3_item_r.blue_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_item_r   <= in_data;
    s1_quo_r    <= quo_nxt;
    s2_item_r   <= s1_item_r;
    s2_hue_r    <= hue_nxt;
    s3_item_r   <= s2_item_r;
    s3_sector_r <= sector_nxt;
    s3_frac_r   <= frac_nxt;
  end

endmodule

>>> sv/hsvapa_queue.sv
module hsvapa_queue (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  input  hsvapa_pkg::color_t                  push_data,
  input  logic                                pop,
  output hsvapa_pkg::color_t                  head,
  output logic                                empty,
  output logic [hsvapa_pkg::QCNT_W-1:0]       count
);

  hsvapa_pkg::color_t                mem_r [hsvapa_pkg::QUEUE_DEPTH];
  logic [hsvapa_pkg::QPTR_W-1:0]     wr_ptr_r, rd_ptr_r;
  logic [hsvapa_pkg::QCNT_W-1:0]     count_r;

  assign head  = mem_r[rd_ptr_r];
  assign empty = (count_r == '0);
  assign count = count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> sv/hsvapa_back.sv
module hsvapa_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  hsvapa_pkg::gains_t    gains,
  input  logic                  q_empty,
  input  hsvapa_pkg::color_t    q_head,
  output logic                  pop,
  output logic                  out_valid,
  output hsvapa_pkg::out_item_t out_data
);

  logic                                 active_r, active_nxt;
  logic [hsvapa_pkg::BYTE_CNT_W-1:0]    cnt_r, cnt_nxt;
  hsvapa_pkg::color_t                   cur_r;
  logic [7:0]                           red_s_r, green_s_r, blue_s_r;
  logic                                 out_valid_r;
  hsvapa_pkg::out_item_t                out_data_r, out_data_nxt;

  // A new color is taken when idle, or as the previous frame reaches its end byte.
  assign pop = !q_empty && (!active_r || cnt_r == hsvapa_pkg::BYTE_END);

  always_comb begin
    active_nxt = active_r;
    cnt_nxt    = cnt_r;
    if (pop) begin
      active_nxt = 1'b1;
      cnt_nxt    = '0;
    end else if (active_r && cnt_r == hsvapa_pkg::BYTE_END) begin
      active_nxt = 1'b0;
    end else if (active_r) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_comb begin
    out_data_nxt.regulator_on = (cur_r.brightness != 8'd0);
    out_data_nxt.last_byte    = (cnt_r == hsvapa_pkg::BYTE_END);
    case (cnt_r)
      hsvapa_pkg::BYTE_GLOBAL:
        out_data_nxt.frame_byte = hsvapa_pkg::GLOBAL_MARK | {3'b000, cur_r.brightness[7:3]};
      hsvapa_pkg::BYTE_BLUE:  out_data_nxt.frame_byte = blue_s_r;
      hsvapa_pkg::BYTE_GREEN: out_data_nxt.frame_byte = green_s_r;
      hsvapa_pkg::BYTE_RED:   out_data_nxt.frame_byte = red_s_r;
      hsvapa_pkg::BYTE_END:   out_data_nxt.frame_byte = hsvapa_pkg::END_MARK;
      default:                out_data_nxt.frame_byte = hsvapa_pkg::START_MARK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= active_r;
    end
  end

  // Scaled channels settle during the start bytes, well before use.
  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= q_head;
    end
    red_s_r    <= hsvapa_pkg::scale_chan(cur_r.red, gains.red_gain);
    green_s_r  <= hsvapa_pkg::scale_chan(cur_r.green, gains.green_gain);
    blue_s_r   <= hsvapa_pkg::scale_chan(cur_r.blue, gains.blue_gain);
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> verif/tb_hsv_to_apa102_frame.sv
`timescale 1ns / 1ps

module tb_hsv_to_apa102_frame;

  localparam logic [hsvapa_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 58;
  localparam int MAX_REPORTS  = 10;

  // Holds the gains and the frame bytes still to come, in order of arrival.
  class frame_scoreboard;
    logic [8:0]            red_gain;
    logic [8:0]            green_gain;
    logic [8:0]            blue_gain;
    hsvapa_pkg::out_item_t pending_bytes[$];
    int                    mismatches;
    int                    bytes_checked;
    int                    commands_noted;

    function new();
      red_gain       = hsvapa_pkg::RED_GAIN_RST;
      green_gain     = hsvapa_pkg::GREEN_GAIN_RST;
      blue_gain      = hsvapa_pkg::BLUE_GAIN_RST;
      mismatches     = 0;
      bytes_checked  = 0;
      commands_noted = 0;
    endfunction

    function void set_gain(logic [hsvapa_pkg::CFG_IDX_W-1:0] idx, logic [8:0] value);
      case (idx)
        hsvapa_pkg::REG_RED_GAIN:   red_gain   = value;
        hsvapa_pkg::REG_GREEN_GAIN: green_gain = value;
        hsvapa_pkg::REG_BLUE_GAIN:  blue_gain  = value;
        default: ;
      endcase
    endfunction

    function logic [7:0] apply_gain(int unsigned chan, logic [8:0] gain);
      int unsigned prod;
      prod = (chan * 32'(gain)) >> 8;
      return (prod > 255) ? hsvapa_pkg::CHAN_MAX : prod[7:0];
    endfunction

    // Six-sector conversion; the fraction within a sector is scaled by 4 so
    // that a full sector spans roughly one unit of 256.
    function void hsv_to_rgb(input int unsigned hue, input int unsigned sat,
                             output int unsigned r, output int unsigned g,
                             output int unsigned b);
      int unsigned h, sector, frac, p, q, t;
      h      = hue % 360;
      sector = h / 60;
      frac   = (h % 60) * 4;
      p      = 256 - sat;
      q      = 256 - ((sat * frac) >> 8);
      t      = 512 - sat - q;
      case (sector)
        0: begin r = 255; g = t;   b = p;   end
        1: begin r = q;   g = 255; b = p;   end
        2: begin r = p;   g = 255; b = t;   end
        3: begin r = p;   g = q;   b = 255; end
        4: begin r = t;   g = p;   b = 255; end
        default: begin r = 255; g = p; b = q; end
      endcase
      if (r > 255) r = 255;
      if (g > 255) g = 255;
      if (b > 255) b = 255;
    endfunction

    function void note_command(hsvapa_pkg::in_item_t c);
      int unsigned           r, g, b;
      logic [7:0]            frame[hsvapa_pkg::FRAME_BYTES];
      hsvapa_pkg::out_item_t beat;
      if (c.cmd == hsvapa_pkg::CMD_HSV) begin
        hsv_to_rgb(32'(c.hue), 32'(c.saturation), r, g, b);
      end else begin
        r = 32'(c.red_in);
        g = 32'(c.green_in);
        b = 32'(c.blue_in);
      end
      for (int i = 0; i < hsvapa_pkg::FRAME_BYTES; i++) frame[i] = hsvapa_pkg::START_MARK;
      frame[hsvapa_pkg::BYTE_GLOBAL] = hsvapa_pkg::GLOBAL_MARK | (c.brightness >> 3);
      frame[hsvapa_pkg::BYTE_BLUE]   = apply_gain(b, blue_gain);
      frame[hsvapa_pkg::BYTE_GREEN]  = apply_gain(g, green_gain);
      frame[hsvapa_pkg::BYTE_RED]    = apply_gain(r, red_gain);
      frame[hsvapa_pkg::BYTE_END]    = hsvapa_pkg::END_MARK;
      for (int i = 0; i < hsvapa_pkg::FRAME_BYTES; i++) begin
        beat.frame_byte   = frame[i];
        beat.last_byte    = (i == hsvapa_pkg::FRAME_BYTES - 1);
        beat.regulator_on = (c.brightness != 8'd0);
        pending_bytes.push_back(beat);
      end
      commands_noted++;
    endfunction

    function void check_byte(hsvapa_pkg::out_item_t got);
      hsvapa_pkg::out_item_t want;
      if (pending_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected frame byte %02h last=%0b reg=%0b", $realtime,
                   got.frame_byte, got.last_byte, got.regulator_on);
        return;
      end
      want = pending_bytes.pop_front();
      bytes_checked++;
      if (got.frame_byte !== want.frame_byte || got.last_byte !== want.last_byte ||
          got.regulator_on !== want.regulator_on) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: byte mismatch: expected %02h last=%0b reg=%0b, got %02h last=%0b reg=%0b",
                   $realtime, want.frame_byte, want.last_byte, want.regulator_on,
                   got.frame_byte, got.last_byte, got.regulator_on);
      end
    endfunction

    function int outstanding();
      return pending_bytes.size();
    endfunction
  endclass

  logic                             clk;
  logic                             rst_n;
  logic                             start;
  logic                             busy;
  hsvapa_pkg::in_item_t             in_data;
  logic                             out_valid;
  hsvapa_pkg::out_item_t            out_data;
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic [hsvapa_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [8:0]                       cfg_data;

  frame_scoreboard sb = new();
  int gain_settings;

  hsv_to_apa102_frame dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Every byte strobe is a beat that cannot be held off.
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_byte(out_data);
  end

  function automatic hsvapa_pkg::in_item_t make_item(logic c, logic [7:0] r, logic [7:0] g,
                                                     logic [7:0] b, logic [15:0] h,
                                                     logic [7:0] s, logic [7:0] v);
    hsvapa_pkg::in_item_t it;
    it.cmd        = c;
    it.red_in     = r;
    it.green_in   = g;
    it.blue_in    = b;
    it.hue        = h;
    it.saturation = s;
    it.brightness = v;
    return it;
  endfunction

  function automatic logic [15:0] pick_hue();
    int unsigned h;
    case ($urandom_range(0, 3))
      0: h = $urandom_range(0, 65535);
      1: h = $urandom_range(0, 359);
      // Land on or next to a sector boundary.
      2: h = 60 * $urandom_range(0, 6) + $urandom_range(0, 2) + 359;
      default: h = 360 * $urandom_range(0, 181) + $urandom_range(0, 4);
    endcase
    return h[15:0];
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic hsvapa_pkg::in_item_t random_item();
    return make_item(1'($urandom_range(0, 1)), pick_byte(), pick_byte(), pick_byte(),
                     pick_hue(), pick_byte(), pick_byte());
  endfunction

  // Idle stretches are common but about three in seven of the items go back to back.
  function automatic int pick_gap();
    return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
  endfunction

  task automatic send_item(hsvapa_pkg::in_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy);
    sb.note_command(it);
  endtask

  task automatic write_gain(logic [hsvapa_pkg::CFG_IDX_W-1:0] idx, logic [8:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.set_gain(idx, value);
  endtask

  task automatic wait_drain();
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  task automatic program_gains(logic [8:0] rg, logic [8:0] gg, logic [8:0] bg);
    start <= 1'b0;
    wait_drain();
    repeat (4) @(posedge clk);
    write_gain(hsvapa_pkg::REG_BLUE_GAIN, bg);
    write_gain(REG_UNUSED, 9'($urandom_range(0, 511)));
    write_gain(hsvapa_pkg::REG_RED_GAIN, rg);
    write_gain(hsvapa_pkg::REG_GREEN_GAIN, gg);
    cfg_valid <= 1'b0;
    gain_settings++;
  endtask

  initial begin
    rst_n     = 1'b0;
    start     = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    gain_settings = 1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed commands under the reset gains.
    send_item(make_item(hsvapa_pkg::CMD_RGB, 8'h00, 8'h00, 8'h00, 16'h0000, 8'h00, 8'h00));
    send_item(make_item(hsvapa_pkg::CMD_RGB, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF, 8'hFF));
    send_item(make_item(hsvapa_pkg::CMD_RGB, 8'h01, 8'h80, 8'hFE, 16'h1234, 8'hA5, 8'h07));
    send_item(make_item(hsvapa_pkg::CMD_RGB, 8'h7F, 8'h00, 8'hFF, 16'd0, 8'd0, 8'h08));
    send_item(make_item(hsvapa_pkg::CMD_HSV, 8'hFF, 8'hFF, 8'hFF, 16'd0, 8'd255, 8'd255));
    send_item(make_item(hsvapa_pkg::CMD_HSV, 8'h00, 8'h00, 8'h00, 16'd0, 8'd0, 8'd128));
    send_item(make_item(hsvapa_pkg::CMD_HSV, 8'h55, 8'hAA, 8'h55, 16'd59, 8'd255, 8'd1));
    send_item(make_item(hsvapa_pkg::CMD_HSV, 8'h00, 8'h00, 8'h00, 16'd60, 8'd255, 8'd200));
    send_item(make_item(hsvapa_pkg::CMD_HSV, 8'h00, 8'h00, 8'h00, 16'd119, 8'd200, 8'd255));
    send_item(make_item(hsvapa_pkg::CMD_HSV, 8'h00, 8'h00, 8'h00, 16'd120, 8'd255, 8'd255));
    send_item(make_item(hsvapa_pkg::CMD_HSV, 8'h00, 8'h00, 8'h00, 16'd180, 8'd128, 8'd0));
    send_item(make_item(hsvapa_pkg::CMD_HSV, 8'h00, 8'h00, 8'h00, 16'd240, 8'd255, 8'd255));
    send_item(make_item(hsvapa_pkg::CMD_HSV, 8'h00, 8'h00, 8'h00, 16'd299, 8'd1, 8'd255));
    send_item(make_item(hsvapa_pkg::CMD_HSV, 8'h00, 8'h00, 8'h00, 16'd300, 8'd255, 8'd255));
    send_item(make_item(hsvapa_pkg::CMD_HSV, 8'h00, 8'h00, 8'h00, 16'd359, 8'd255, 8'd255));
    send_item(make_item(hsvapa_pkg::CMD_HSV, 8'h00, 8'h00, 8'h00, 16'd360, 8'd255, 8'd255));
    send_item(make_item(hsvapa_pkg::CMD_HSV, 8'h00, 8'h00, 8'h00, 16'd65535, 8'd255, 8'd255));
    send_item(make_item(hsvapa_pkg::CMD_HSV, 8'h00, 8'h00, 8'h00, 16'd65535, 8'd0, 8'd255));
    send_item(make_item(hsvapa_pkg::CMD_HSV, 8'hFF, 8'hFF, 8'hFF, 16'd30, 8'd100, 8'd0));

    // Saturating gains above unit, then zero gains.
    program_gains(9'd511, 9'd511, 9'd511);
    send_item(make_item(hsvapa_pkg::CMD_RGB, 8'hFF, 8'h80, 8'h01, 16'd0, 8'd0, 8'd255));
    send_item(make_item(hsvapa_pkg::CMD_HSV, 8'h00, 8'h00, 8'h00, 16'd90, 8'd180, 8'd255));
    program_gains(9'd0, 9'd0, 9'd0);
    send_item(make_item(hsvapa_pkg::CMD_RGB, 8'hFF, 8'hFF, 8'hFF, 16'd0, 8'd0, 8'd255));

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: program_gains(9'd256, 9'd256, 9'd256);
        1: program_gains(9'd0, 9'd256, 9'd511);
        2: program_gains(hsvapa_pkg::RED_GAIN_RST, hsvapa_pkg::GREEN_GAIN_RST,
                         hsvapa_pkg::BLUE_GAIN_RST);
        3: program_gains(9'd511, 9'd1, 9'd255);
        default: program_gains(9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)),
                               9'($urandom_range(0, 511)));
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) send_item(random_item());
    end

    start <= 1'b0;
    wait_drain();
    repeat (20) @(posedge clk);

    $display("summary: %0d commands over %0d gain settings, %0d frame bytes checked",
             sb.commands_noted, gain_settings, sb.bytes_checked);
    $display("summary: %0d mismatches, %0d bytes never arrived",
             sb.mismatches, sb.outstanding());
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d frame bytes outstanding", sb.outstanding());
    $display("tb: failure");
    $finish;
  end

endmodule
